// File: design/pes_pkg.sv
// Shared types, constants and helpers for the particle Euler step pipeline.
package pes_pkg;

  localparam int DataW   = 32;
  localparam int TsW     = 17;
  localparam int DcW     = 17;
  localparam int GrW     = 24;
  localparam int CfgW    = 24;
  localparam int CfgIdxW = 2;
  localparam int GpW     = GrW + TsW;
  localparam int SqrtLat = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgTimeStep = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDragCoef = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGravity  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [TsW-1:0] TimeStepRst = 17'd6554;
  localparam logic [DcW-1:0] DragCoefRst = 17'd3277;
  localparam logic [GrW-1:0] GravityRst  = 24'd642253;

  // Word carried alongside the square-root pipeline.
  typedef struct packed {
    logic [2:0][DataW-1:0] npos;
    logic [2:0][DataW-1:0] vel;
    logic [GpW-1:0]        gp;
    logic                  frozen;
    logic                  expired;
    logic                  last;
  } pes_item_t;

  // Saturate a signed value to the signed 32-bit range.
  function automatic logic [DataW-1:0] sat32(input logic signed [63:0] x);
    logic [DataW-1:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[DataW-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/particle_euler_step_with_drag.sv
// An accepted start passes stages 1 and 2, the square root, stages 3 to 6 and the output register.
// Throughput: one word per cycle; the pipeline never stalls, so busy_o stays low.
// The depth is set mostly by the 32-stage square root of the speed.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset clears all valid bits and loads the register defaults.
module particle_euler_step_with_drag #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          cfg_we_i,
  input  logic [pes_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pes_pkg::CfgW-1:0]      cfg_data_i,
  input  logic signed [31:0]            position_x_i,
  input  logic signed [31:0]            position_y_i,
  input  logic signed [31:0]            position_z_i,
  input  logic signed [31:0]            velocity_x_i,
  input  logic signed [31:0]            velocity_y_i,
  input  logic signed [31:0]            velocity_z_i,
  input  logic [31:0]                   current_time_i,
  input  logic [31:0]                   particle_end_time_i,
  input  logic [31:0]                   explosion_end_time_i,
  input  logic                          last_particle_in_i,
  output logic                          valid_o,
  output logic signed [31:0]            new_position_x_o,
  output logic signed [31:0]            new_position_y_o,
  output logic signed [31:0]            new_position_z_o,
  output logic signed [31:0]            new_velocity_x_o,
  output logic signed [31:0]            new_velocity_y_o,
  output logic signed [31:0]            new_velocity_z_o,
  output logic                          explosion_expired_o,
  output logic                          last_particle_out_o
);
  import pes_pkg::*;

  localparam int PmW  = DataW + TsW + 1;
  localparam int P1W  = DataW + DcW;
  localparam int D1W  = 2*FRAC_BITS + 2;
  localparam int P2W  = D1W + TsW;
  localparam int ScW  = FRAC_BITS + 1;
  localparam int VmW  = DataW + ScW + 1;
  localparam logic [63:0] D1Lim = 64'd1 << (2*FRAC_BITS + 1);
  localparam logic [63:0] One   = 64'd1 << FRAC_BITS;

  // Configuration registers.
  logic [TsW-1:0] ts_q;
  logic [DcW-1:0] dc_q;
  logic [GrW-1:0] gr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= TimeStepRst;
      dc_q <= DragCoefRst;
      gr_q <= GravityRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTimeStep: ts_q <= cfg_data_i[TsW-1:0];
        CfgDragCoef: dc_q <= cfg_data_i[DcW-1:0];
        CfgGravity:  gr_q <= cfg_data_i[GrW-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // Stage 1: squares, position increments and the gravity product.
  logic [DataW-1:0] vin [3];
  logic [DataW-1:0] pin [3];
  logic [DataW-1:0] absv [3];
  assign vin[0] = velocity_x_i;
  assign vin[1] = velocity_y_i;
  assign vin[2] = velocity_z_i;
  assign pin[0] = position_x_i;
  assign pin[1] = position_y_i;
  assign pin[2] = position_z_i;

  for (genvar i = 0; i < 3; i++) begin : g_abs
    assign absv[i] = vin[i][DataW-1] ? (~vin[i] + 32'd1) : vin[i];
  end

  logic                  s1_valid_q;
  logic [63:0]           s1_sq_q  [3];
  logic signed [PmW-1:0] s1_pm_q  [3];
  logic [DataW-1:0]      s1_pos_q [3];
  logic [DataW-1:0]      s1_vel_q [3];
  logic [GpW-1:0]        s1_gp_q;
  logic                  s1_frozen_q, s1_exp_q, s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      s1_sq_q[i]  <= 64'(absv[i]) * 64'(absv[i]);
      s1_pm_q[i]  <= PmW'($signed(vin[i]) * $signed({1'b0, ts_q}));
      s1_pos_q[i] <= pin[i];
      s1_vel_q[i] <= vin[i];
    end
    s1_gp_q     <= GpW'(gr_q) * GpW'(ts_q);
    s1_frozen_q <= current_time_i > particle_end_time_i;
    s1_exp_q    <= current_time_i > explosion_end_time_i;
    s1_last_q   <= last_particle_in_i;
  end

  // Stage 2: sum of squares and the saturated new position (the old one if frozen).
  logic        s2_valid_q;
  logic [63:0] s2_sum_q;
  pes_item_t   s2_pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_sum_q <= s1_sq_q[0] + s1_sq_q[1] + s1_sq_q[2];
    for (int i = 0; i < 3; i++) begin
      s2_pay_q.npos[i] <= s1_frozen_q ? s1_pos_q[i] :
        sat32(64'($signed(s1_pos_q[i])) + (64'(s1_pm_q[i]) >>> FRAC_BITS));
      s2_pay_q.vel[i]  <= s1_vel_q[i];
    end
    s2_pay_q.gp      <= s1_gp_q;
    s2_pay_q.frozen  <= s1_frozen_q;
    s2_pay_q.expired <= s1_exp_q;
    s2_pay_q.last    <= s1_last_q;
  end

  // Speed by pipelined square root; the word rides a matching delay line.
  logic             sq_valid;
  logic [DataW-1:0] sq_root;

  pes_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid_q),
    .rad_i   (s2_sum_q),
    .valid_o (sq_valid),
    .root_o  (sq_root)
  );

  pes_item_t dl_q [SqrtLat];

  always_ff @(posedge clk_i) begin
    dl_q[0] <= s2_pay_q;
    for (int k = 1; k < SqrtLat; k++) begin
      dl_q[k] <= dl_q[k-1];
    end
  end

  // Stages 3 to 5: drag factor and velocity scale.
  logic           s3_valid_q, s4_valid_q, s5_valid_q;
  logic [P1W-1:0] s3_p1_q;
  logic [P2W-1:0] s4_p2_q;
  logic [ScW-1:0] s5_scale_q;
  pes_item_t      s3_pay_q, s4_pay_q, s5_pay_q;
  logic [63:0]    d1, d1c, d2, drag;

  always_comb begin
    d1   = 64'(s3_p1_q) >> FRAC_BITS;
    d1c  = (d1 > D1Lim) ? D1Lim : d1;
    d2   = 64'(s4_p2_q) >> FRAC_BITS;
    drag = (d2 > One) ? One : d2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= sq_valid;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_p1_q    <= P1W'(sq_root) * P1W'(dc_q);
    s3_pay_q   <= dl_q[SqrtLat-1];
    s4_p2_q    <= P2W'(d1c[D1W-1:0]) * P2W'(ts_q);
    s4_pay_q   <= s3_pay_q;
    s5_scale_q <= ScW'(One - drag);
    s5_pay_q   <= s4_pay_q;
  end

  // Stage 6: scale each velocity component.
  logic                  s6_valid_q;
  logic signed [VmW-1:0] s6_vm_q [3];
  pes_item_t             s6_pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else begin
      s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      s6_vm_q[i] <= VmW'($signed(s5_pay_q.vel[i]) * $signed({1'b0, s5_scale_q}));
    end
    s6_pay_q <= s5_pay_q;
  end

  // Stage 7: gravity on the vertical velocity, frozen bypass, output register.
  logic signed [63:0] nvx, nvy, nvz, dv;

  always_comb begin
    nvx = 64'(s6_vm_q[0]) >>> FRAC_BITS;
    nvz = 64'(s6_vm_q[2]) >>> FRAC_BITS;
    dv  = $signed(64'(s6_pay_q.gp >> FRAC_BITS));
    nvy = (64'(s6_vm_q[1]) >>> FRAC_BITS) - dv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= s6_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    new_position_x_o    <= s6_pay_q.npos[0];
    new_position_y_o    <= s6_pay_q.npos[1];
    new_position_z_o    <= s6_pay_q.npos[2];
    new_velocity_x_o    <= s6_pay_q.frozen ? s6_pay_q.vel[0] : nvx[DataW-1:0];
    new_velocity_y_o    <= s6_pay_q.frozen ? s6_pay_q.vel[1] : sat32(nvy);
    new_velocity_z_o    <= s6_pay_q.frozen ? s6_pay_q.vel[2] : nvz[DataW-1:0];
    explosion_expired_o <= s6_pay_q.expired;
    last_particle_out_o <= s6_pay_q.last;
  end

endmodule

// File: design/pes_isqrt.sv
// Fully pipelined integer square root, one result bit per stage.
module pes_isqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [63:0]              rad_i,
  output logic                     valid_o,
  output logic [pes_pkg::DataW-1:0] root_o
);
  import pes_pkg::*;

  logic        valid_q [SqrtLat];
  logic [63:0] rem_q   [SqrtLat];
  logic [63:0] root_q  [SqrtLat];

  for (genvar k = 0; k < SqrtLat; k++) begin : g_step
    logic [63:0] rem_in, root_in, bitc, trial;
    logic        vin;

    // Each stage tests one bit of the root against the running remainder.
    assign rem_in  = (k == 0) ? rad_i : rem_q[(k == 0) ? 0 : k-1];
    assign root_in = (k == 0) ? 64'd0 : root_q[(k == 0) ? 0 : k-1];
    assign vin     = (k == 0) ? valid_i : valid_q[(k == 0) ? 0 : k-1];
    assign bitc    = 64'd1 << (62 - 2*k);
    assign trial   = root_in + bitc;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rem_in >= trial) begin
        rem_q[k]  <= rem_in - trial;
        root_q[k] <= (root_in >> 1) + bitc;
      end else begin
        rem_q[k]  <= rem_in;
        root_q[k] <= root_in >> 1;
      end
    end
  end

  assign valid_o = valid_q[SqrtLat-1];
  assign root_o  = root_q[SqrtLat-1][DataW-1:0];

endmodule
